>>> rtl/pbns_pkg.sv
// pbns_pkg: shared constants and codes for the periodic bond neighbor search
// no dependencies
`timescale 1ns / 1ps
package pbns_pkg;
	localparam int COORD_W = 24;
	localparam int RAD_W = 16;
	localparam int SCALE_W = 12;
	localparam int IDX_W = 10;
	localparam int DSQ_W = 50;
	localparam int TOTAL_W = 4;
	localparam int RESULT_CAP = 7;

	localparam logic [COORD_W-1:0] HIDE_X = 24'd2560000;

	localparam logic [COORD_W-1:0] BOX_RESET = 24'd25600;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd1362;

	// result kinds
	localparam logic [1:0] KIND_BOND = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_LIMIT = 2'd2;
	localparam logic [1:0] KIND_FULL = 2'd3;

	// register indexes
	localparam logic [1:0] REG_BOX_X = 2'd0;
	localparam logic [1:0] REG_BOX_Y = 2'd1;
	localparam logic [1:0] REG_BOX_Z = 2'd2;
	localparam logic [1:0] REG_SCALE = 2'd3;
endpackage

>>> rtl/pbns_if.sv
// pbns channel interfaces: atom beats in, bond result beats out
// depends on pbns_pkg
`timescale 1ns / 1ps
interface pbns_atom_if import pbns_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;
	logic [COORD_W-1:0] z_coord;
	logic [RAD_W-1:0] radius;
	logic last_atom;
	modport source (output valid, x_coord, y_coord, z_coord, radius, last_atom, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, radius, last_atom, output ready);
endinterface

interface pbns_bond_if import pbns_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [IDX_W-1:0] atom_index;
	logic [IDX_W-1:0] partner_index;
	logic [DSQ_W-1:0] distance_sq;
	logic [TOTAL_W-1:0] neighbor_total;
	logic last;
	modport source (output valid, kind, atom_index, partner_index, distance_sq,
		neighbor_total, last, input ready);
	modport sink (input valid, kind, atom_index, partner_index, distance_sq,
		neighbor_total, last, output ready);
endinterface

>>> rtl/pbns_ram.sv
// pbns_ram: simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
module pbns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/periodic_bond_neighbor_search.sv
// Periodic bond neighbor search. Each atom beat that finds room is stored, and a visible
// one is compared with every earlier visible atom of its frame under the minimum-image
// rule until a limit error ends the walk; bonds, a done beat or an error beat come out
// afterwards, all carrying the new atom's final neighbor count. One 29x29 multiplier is
// shared by all products of a pair: a visible earlier atom passes S_RD, S_MX, S_MY, S_MZ,
// S_MC, S_MCC and S_CMP, a hidden one S_RD and S_MX. The block takes no atom while a walk
// or its results are pending. Depends on pbns_pkg, pbns_if and pbns_ram.
`timescale 1ns / 1ps
module periodic_bond_neighbor_search import pbns_pkg::*; #(
	parameter int MAX_ATOMS = 1024,
	parameter int NEIGHBOR_LIMIT = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	pbns_atom_if.sink atoms,
	pbns_bond_if.source bonds
);
	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW = $clog2(NEIGHBOR_LIMIT + 1);
	localparam int EW = 3 * COORD_W + RAD_W + 1;
	localparam int MW = 29;
	localparam logic [AW:0] MAX_CNT = (AW + 1)'(MAX_ATOMS);
	localparam logic [CW-1:0] LIMIT = CW'(NEIGHBOR_LIMIT);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_MX = 4'd2;
	localparam logic [3:0] S_MY = 4'd3;
	localparam logic [3:0] S_MZ = 4'd4;
	localparam logic [3:0] S_MC = 4'd5;
	localparam logic [3:0] S_MCC = 4'd6;
	localparam logic [3:0] S_CMP = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [COORD_W-1:0] box_x_q, box_y_q, box_z_q;
	logic [SCALE_W-1:0] scale_q;
	logic [AW:0] counter_q, idx_q, p_q;
	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [RAD_W-1:0] rad_q;
	logic err_q;
	logic [CW-1:0] total_q;
	logic [2:0] n_q, e_q;
	logic [2*MW-1:0] prod_q;
	logic [DSQ_W-1:0] acc_q;
	logic [1:0] buf_kind_q [RESULT_CAP];
	logic [IDX_W-1:0] buf_partner_q [RESULT_CAP];
	logic [DSQ_W-1:0] buf_dsq_q [RESULT_CAP];

	logic accept, full, hid_in;
	logic [EW-1:0] ent_rd;
	logic [CW-1:0] cnt_rd;
	logic cnt_we;
	logic [AW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [COORD_W-1:0] s_x, s_y, s_z, ga, gb, gbox, gap;
	logic [COORD_W-1:0] d;
	logic [COORD_W:0] wrapped;
	logic [RAD_W-1:0] s_rad;
	logic s_hid;
	logic [MW-1:0] mul_a, mul_b;
	logic [2*MW-1:0] prod;
	logic bond, bond_err;

	assign accept = atoms.valid && atoms.ready;
	assign atoms.ready = (state_q == S_IDLE);
	assign full = (counter_q >= MAX_CNT);
	assign hid_in = (atoms.x_coord > HIDE_X);
	assign {s_x, s_y, s_z, s_rad, s_hid} = ent_rd;

	pbns_ram #(.WIDTH(EW), .DEPTH(MAX_ATOMS)) u_entry_ram (
		.clk(clk),
		.we(accept && !full),
		.waddr(counter_q[AW-1:0]),
		.wdata({atoms.x_coord, atoms.y_coord, atoms.z_coord, atoms.radius, hid_in}),
		.raddr(p_q[AW-1:0]),
		.rdata(ent_rd)
	);

	pbns_ram #(.WIDTH(CW), .DEPTH(MAX_ATOMS)) u_count_ram (
		.clk(clk),
		.we(cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(p_q[AW-1:0]),
		.rdata(cnt_rd)
	);

	// shared minimum-image gap unit, axis picked by the step
	always_comb begin
		case (state_q)
			S_MY: begin
				ga = y_q; gb = s_y; gbox = box_y_q;
			end
			S_MZ: begin
				ga = z_q; gb = s_z; gbox = box_z_q;
			end
			default: begin
				ga = x_q; gb = s_x; gbox = box_x_q;
			end
		endcase
		d = (ga > gb) ? ga - gb : gb - ga;
		wrapped = {1'b0, gbox} - {1'b0, d};
		if ({d, 1'b0} > {1'b0, gbox}) begin
			gap = wrapped[COORD_W] ? COORD_W'(-wrapped) : wrapped[COORD_W-1:0];
		end else begin
			gap = d;
		end
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			S_MC: begin
				mul_a = MW'(scale_q);
				mul_b = MW'({1'b0, rad_q} + {1'b0, s_rad});
			end
			S_MCC: begin
				mul_a = prod_q[MW-1:0];
				mul_b = prod_q[MW-1:0];
			end
			default: begin
				mul_a = MW'(gap);
				mul_b = MW'(gap);
			end
		endcase
		prod = mul_a * mul_b;
	end

	assign bond = ({8'd0, acc_q} <= (prod_q >> 20));
	assign bond_err = (cnt_rd >= LIMIT) || (total_q >= LIMIT)
		|| (n_q >= 3'(RESULT_CAP - 1));

	always_comb begin
		cnt_we = 1'b0;
		cnt_waddr = p_q[AW-1:0];
		cnt_wdata = cnt_rd + 1'b1;
		if (state_q == S_CMP && bond && !bond_err) begin
			cnt_we = 1'b1;
		end else if (state_q == S_DONE) begin
			cnt_we = 1'b1;
			cnt_waddr = idx_q[AW-1:0];
			cnt_wdata = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			box_x_q <= BOX_RESET;
			box_y_q <= BOX_RESET;
			box_z_q <= BOX_RESET;
			scale_q <= SCALE_RESET;
			counter_q <= '0;
			n_q <= '0;
			e_q <= '0;
			total_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BOX_X: box_x_q <= cfg_data;
					REG_BOX_Y: box_y_q <= cfg_data;
					REG_BOX_Z: box_z_q <= cfg_data;
					REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= counter_q;
						x_q <= atoms.x_coord;
						y_q <= atoms.y_coord;
						z_q <= atoms.z_coord;
						rad_q <= atoms.radius;
						p_q <= '0;
						total_q <= '0;
						err_q <= 1'b0;
						e_q <= '0;
						if (atoms.last_atom) begin
							counter_q <= '0;
						end else if (!full) begin
							counter_q <= counter_q + 1'b1;
						end
						if (full) begin
							buf_kind_q[0] <= KIND_FULL;
							buf_partner_q[0] <= '0;
							buf_dsq_q[0] <= '0;
							n_q <= 3'd1;
							state_q <= S_EMIT;
						end else begin
							n_q <= '0;
							state_q <= hid_in ? S_DONE : S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= (p_q == idx_q) ? S_DONE : S_MX;
				end
				S_MX: begin
					if (s_hid) begin
						p_q <= p_q + 1'b1;
						state_q <= S_RD;
					end else begin
						prod_q <= prod;
						state_q <= S_MY;
					end
				end
				S_MY: begin
					acc_q <= prod_q[DSQ_W-1:0];
					prod_q <= prod;
					state_q <= S_MZ;
				end
				S_MZ: begin
					acc_q <= acc_q + prod_q[DSQ_W-1:0];
					prod_q <= prod;
					state_q <= S_MC;
				end
				S_MC: begin
					acc_q <= acc_q + prod_q[DSQ_W-1:0];
					prod_q <= prod;
					state_q <= S_MCC;
				end
				S_MCC: begin
					prod_q <= prod;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (bond) begin
						buf_partner_q[n_q] <= IDX_W'(p_q);
						n_q <= n_q + 1'b1;
						if (bond_err) begin
							buf_kind_q[n_q] <= KIND_LIMIT;
							buf_dsq_q[n_q] <= '0;
							err_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							buf_kind_q[n_q] <= KIND_BOND;
							buf_dsq_q[n_q] <= acc_q;
							total_q <= total_q + 1'b1;
							p_q <= p_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						p_q <= p_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!err_q) begin
						buf_kind_q[n_q] <= KIND_DONE;
						buf_partner_q[n_q] <= '0;
						buf_dsq_q[n_q] <= '0;
						n_q <= n_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (bonds.ready) begin
						if (e_q == n_q - 1'b1) begin
							state_q <= S_IDLE;
						end else begin
							e_q <= e_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign bonds.valid = (state_q == S_EMIT);
	assign bonds.kind = buf_kind_q[e_q];
	assign bonds.atom_index = IDX_W'(idx_q);
	assign bonds.partner_index = buf_partner_q[e_q];
	assign bonds.distance_sq = buf_dsq_q[e_q];
	assign bonds.neighbor_total = TOTAL_W'(total_q);
	assign bonds.last = (e_q == n_q - 1'b1);

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		atoms.ready |-> !bonds.valid) else $error("input ready while results pending");
	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 3'(RESULT_CAP)) else $error("result buffer overrun");
	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= LIMIT) else $error("neighbor total past limit");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MX) |-> (p_q < idx_q)) else $error("walk past new atom");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bonds.valid |-> (e_q < n_q)) else $error("emit pointer past results");
endmodule
